// ===== hw/rtl/haar_subband_analysis_top_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef HAAR_SUBBAND_ANALYSIS_TOP_MACROS_SVH
`define HAAR_SUBBAND_ANALYSIS_TOP_MACROS_SVH

// checked property, held off while reset is asserted
`define HSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property that also holds during reset
`define HSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/hsa_pkg.sv =====
package hsa_pkg;

  // field widths
  localparam int unsigned PIXEL_W = 8;
  localparam int unsigned COEF_W  = 10;
  localparam int unsigned BCOL_W  = 9;
  localparam int unsigned WIDTH_W = 11;

  // width register reset and default row store size
  localparam logic [WIDTH_W-1:0] WIDTH_RESET   = 11'd512;
  localparam int unsigned        MAX_WIDTH_DEF = 1024;

endpackage

// ===== hw/rtl/hsa_if.sv =====
// pixel input channel
interface hsa_pix_if;
  import hsa_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// subband coefficient output channel
interface hsa_coef_if;
  import hsa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [COEF_W-1:0] ll_x4;
  logic signed [COEF_W-1:0] lh_x4;
  logic signed [COEF_W-1:0] hl_x4;
  logic signed [COEF_W-1:0] hh_x4;
  logic        [BCOL_W-1:0] block_column;

  modport source (output valid, output ll_x4, output lh_x4, output hl_x4, output hh_x4,
                  output block_column, input ready);
  modport sink   (input valid, input ll_x4, input lh_x4, input hl_x4, input hh_x4,
                  input block_column, output ready);
endinterface

// image width write channel
interface hsa_cfg_if;
  import hsa_pkg::*;

  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hsa_ram.sv =====
module hsa_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // single write port, registered read port holding its last word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/haar_subband_analysis_top.sv =====
// One-level 2-D Haar analysis of a raster pixel stream.
// pix_i takes one 8-bit pixel per transaction in raster order; frame_start
// marks the first pixel of a frame and clears column and row parity.
// cfg_i writes the row width (even, 2..MaxWidth); it is always ready. It must
// be written only while no pixel is in flight; the block does not enforce this.
// Odd values are rounded down and clamped to 2..MaxWidth.
// Pixels of even rows go to two row RAMs, split by column parity, so the
// two upper pixels of a 2x2 block come out of one read. On odd rows the
// left pixel of each pair issues that read and is held in a register.
// The right pixel completes the block and one coef_o transaction carries
// ll, lh, hl, hh (all times four) and the block column.
// Throughput: one pixel per cycle unless coef_o stalls (one access per row RAM per cycle).
// Latency: the result is valid in the cycle after its pixel is taken.
// A finished result sits in the output register; pix_i stays ready while
// it is taken in the same cycle, and drops ready only while coef_o stalls.
// Reset clears position, row parity and the held pixel and sets the width
// to 512. Row RAM contents are undefined until written; no clearing pass.
`include "haar_subband_analysis_top_macros.svh"

module haar_subband_analysis_top #(
  parameter int unsigned MaxWidth = hsa_pkg::MAX_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  hsa_cfg_if.sink  cfg_i,
  hsa_pix_if.sink  pix_i,
  hsa_coef_if.source coef_o
);
  import hsa_pkg::*;

  localparam int unsigned ColW   = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned EffW   = ($clog2(MaxWidth + 1) > WIDTH_W) ?
                                   $clog2(MaxWidth + 1) : WIDTH_W;
  localparam int unsigned TopW   = MaxWidth - (MaxWidth % 2);
  localparam int unsigned HalfD  = MaxWidth / 2;
  localparam int unsigned RamAw  = (HalfD > 1) ? $clog2(HalfD) : 1;
  localparam int unsigned ColExW = (ColW > BCOL_W + 1) ? ColW : BCOL_W + 1;

  logic [WIDTH_W-1:0] width_q;
  logic [ColW-1:0]    col_q, col_d;
  logic               odd_q, odd_d;
  logic [PIXEL_W-1:0] left_q, left_d;

  logic               acc;
  logic [ColW-1:0]    col_cur;
  logic               odd_cur;
  logic [EffW-1:0]    eff_w, w_even, col_nxt;
  logic [RamAw-1:0]   pair_addr;
  logic               we_even, we_odd, rd_pair, emit;
  logic [PIXEL_W-1:0] up_left, up_right;

  logic [COEF_W-1:0]  ll_d, lh_d, hl_d, hh_d;
  logic [COEF_W-1:0]  sum_ab, sum_cd, dif_ab, dif_cd;
  logic [ColExW-1:0]  col_ext;

  logic               out_valid_q, out_valid_d;
  logic [COEF_W-1:0]  ll_q, lh_q, hl_q, hh_q;
  logic [BCOL_W-1:0]  bcol_q;

  // width register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
    end else if (cfg_i.valid) begin
      width_q <= cfg_i.data;
    end
  end

  // effective width: even, clamped to 2..top
  always_comb begin
    w_even = EffW'(width_q) & ~EffW'(1);
    if (w_even < EffW'(2)) begin
      eff_w = EffW'(2);
    end else if (w_even > EffW'(TopW)) begin
      eff_w = EffW'(TopW);
    end else begin
      eff_w = w_even;
    end
  end

  // position of the incoming pixel
  assign pix_i.ready = !out_valid_q || coef_o.ready;
  assign acc         = pix_i.valid && pix_i.ready;
  assign col_cur     = pix_i.frame_start ? '0 : col_q;
  assign odd_cur     = pix_i.frame_start ? 1'b0 : odd_q;
  assign pair_addr   = RamAw'(col_cur >> 1);

  // row RAM access: writes on even rows, pair read on left pixel of odd rows
  assign we_even = acc && !odd_cur && !col_cur[0];
  assign we_odd  = acc && !odd_cur && col_cur[0];
  assign rd_pair = acc && odd_cur && !col_cur[0];
  assign emit    = acc && odd_cur && col_cur[0];

  hsa_ram #(
    .Width (PIXEL_W),
    .Depth (HalfD)
  ) u_even_ram (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (pair_addr),
    .wdata_i (pix_i.pixel),
    .re_i    (rd_pair),
    .raddr_i (pair_addr),
    .rdata_o (up_left)
  );

  hsa_ram #(
    .Width (PIXEL_W),
    .Depth (HalfD)
  ) u_odd_ram (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (pair_addr),
    .wdata_i (pix_i.pixel),
    .re_i    (rd_pair),
    .raddr_i (pair_addr),
    .rdata_o (up_right)
  );

  // column advance and row parity
  always_comb begin
    col_nxt = EffW'(col_cur) + EffW'(1);
    col_d   = col_q;
    odd_d   = odd_q;
    left_d  = left_q;
    if (acc) begin
      if (col_nxt >= eff_w) begin
        col_d = '0;
        odd_d = !odd_cur;
      end else begin
        col_d = col_nxt[ColW-1:0];
        odd_d = odd_cur;
      end
      if (rd_pair) begin
        left_d = pix_i.pixel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      odd_q  <= 1'b0;
      left_q <= '0;
    end else begin
      col_q  <= col_d;
      odd_q  <= odd_d;
      left_q <= left_d;
    end
  end

  // subbands of a b / c d, modulo 2^10
  always_comb begin
    sum_ab = COEF_W'(up_left) + COEF_W'(up_right);
    sum_cd = COEF_W'(left_q) + COEF_W'(pix_i.pixel);
    dif_ab = COEF_W'(up_left) - COEF_W'(up_right);
    dif_cd = COEF_W'(left_q) - COEF_W'(pix_i.pixel);
    ll_d   = sum_ab + sum_cd;
    lh_d   = sum_ab - sum_cd;
    hl_d   = dif_ab + dif_cd;
    hh_d   = dif_ab - dif_cd;
  end

  assign col_ext = ColExW'(col_cur);

  // output register
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (coef_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ll_q   <= ll_d;
      lh_q   <= lh_d;
      hl_q   <= hl_d;
      hh_q   <= hh_d;
      bcol_q <= col_ext[BCOL_W:1];
    end
  end

  assign coef_o.valid        = out_valid_q;
  assign coef_o.ll_x4        = ll_q;
  assign coef_o.lh_x4        = $signed(lh_q);
  assign coef_o.hl_x4        = $signed(hl_q);
  assign coef_o.hh_x4        = $signed(hh_q);
  assign coef_o.block_column = bcol_q;

  // checks
  `HSA_ASSERT(a_emit_source, clk_i, rst_ni,
              $rose(out_valid_q) |-> $past(acc && odd_cur && col_cur[0]),
              "result raised without a bottom-right pixel")
  `HSA_ASSERT(a_coef_parity, clk_i, rst_ni,
              out_valid_q |-> (ll_q[0] == lh_q[0]) && (ll_q[0] == hl_q[0]) &&
                              (ll_q[0] == hh_q[0]),
              "subband parities disagree")
  `HSA_ASSERT(a_frame_restart, clk_i, rst_ni,
              (acc && pix_i.frame_start) |=> (col_q == ColW'(1)) && !odd_q,
              "frame start did not restart position")
  `HSA_ASSERT_ALWAYS(a_col_bound, clk_i,
                     EffW'(col_q) < EffW'(TopW),
                     "column beyond row store")

endmodule
